/* hdl/spqp_pkg.sv */
// ----------------------------------------------------------------------------
// spqp_pkg
// Shared types and constants of the setpoint queue planner: input opcodes,
// register indexes, field widths, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package spqp_pkg;

  localparam int unsigned POS_W      = 17;
  localparam int unsigned SPEED_W    = 26;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned AXIS_W     = 3;
  localparam int unsigned THR_W      = 7;
  localparam int unsigned RATE_W     = 10;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_AXES    = 6;

  localparam logic [THR_W-1:0]   THR_RESET  = 7'd10;
  localparam logic [RATE_W-1:0]  RATE_RESET = 10'd20;
  localparam logic [OFF_W-1:0]   OFF_RESET  = 16'd500;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FACTOR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_OFFSET    = 2'd2;

  typedef enum logic [1:0] {
    OP_GOOD_FRAME = 2'd0,
    OP_BAD_FRAME  = 2'd1,
    OP_TICK       = 2'd2,
    OP_LINK_LOST  = 2'd3
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;    // capture the accepted transaction
    logic rd_en;        // read one queue row
    logic rd_next;      // read the row after the head instead of the head
    logic pop;          // latch the head row and advance the head
    logic take_next;    // latch the look-ahead row, restart the axis count
    logic calc_diff;    // mean step difference of the current axis
    logic calc_mul;     // scale by the rate factor
    logic emit_move;    // load a move result
    logic emit_status;  // apply the item and load its status result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic can_deq;
    logic out_free;
    logic last_axis;
  } status_t;

endpackage

/* hdl/stepper_setpoint_queue_planner.sv */
// Sequence: a frame, link-loss or non-dequeuing tick gives its registered status
//   result once the output is free; the next item is taken once back in idle.
// Flow: one transaction at a time; a dequeuing tick reads the head and look-ahead
//   rows, then runs the shared difference/multiply/offset step for each axis.
// Reset: clears pointers, fill, primed, enabled, previous positions and sets
//   registers to their defaults; queue memory contents stay undefined.
// ----------------------------------------------------------------------------
// stepper_setpoint_queue_planner
// Multi-axis setpoint queue with priming and a per-axis speed planner.
// ----------------------------------------------------------------------------
module stepper_setpoint_queue_planner #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned AXES        = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spqp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spqp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic signed [spqp_pkg::POS_W-1:0] pos_a_i,
  input  logic signed [spqp_pkg::POS_W-1:0] pos_b_i,
  input  logic signed [spqp_pkg::POS_W-1:0] pos_c_i,
  input  logic signed [spqp_pkg::POS_W-1:0] pos_d_i,
  input  logic signed [spqp_pkg::POS_W-1:0] pos_e_i,
  input  logic signed [spqp_pkg::POS_W-1:0] pos_f_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              kind_o,
  output logic [spqp_pkg::AXIS_W-1:0]       axis_o,
  output logic signed [spqp_pkg::POS_W-1:0] target_o,
  output logic [spqp_pkg::SPEED_W-1:0]      max_speed_o,
  output logic                              outputs_enabled_o,
  output logic                              dropped_o,
  output logic [spqp_pkg::FILL_W-1:0]       fill_o,
  output logic                              last_o
);
  import spqp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  spqp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spqp_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AXES        (AXES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .pos_a_i           (pos_a_i),
    .pos_b_i           (pos_b_i),
    .pos_c_i           (pos_c_i),
    .pos_d_i           (pos_d_i),
    .pos_e_i           (pos_e_i),
    .pos_f_i           (pos_f_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .axis_o            (axis_o),
    .target_o          (target_o),
    .max_speed_o       (max_speed_o),
    .outputs_enabled_o (outputs_enabled_o),
    .dropped_o         (dropped_o),
    .fill_o            (fill_o),
    .last_o            (last_o)
  );

endmodule

/* hdl/spqp_ctrl.sv */
// ----------------------------------------------------------------------------
// spqp_ctrl
// Sequencer of the setpoint queue planner: accepts one transaction at a time
// and steps the datapath through status handling or a per-axis dequeue.
// ----------------------------------------------------------------------------
module spqp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  spqp_pkg::status_t status_i,
  output spqp_pkg::cmd_t    cmd_o
);
  import spqp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_NOW,
    S_NEXT,
    S_DIFF,
    S_MUL,
    S_MOVE,
    S_STAT
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.op == OP_TICK && status_i.can_deq) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_NOW;
        end else begin
          state_d = S_STAT;
        end
      end
      S_NOW: begin
        // fetch the look-ahead row while the head row is latched
        cmd_o.pop     = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.take_next = 1'b1;
        state_d         = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.calc_diff = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = S_MOVE;
      end
      S_MOVE: begin
        if (status_i.out_free) begin
          cmd_o.emit_move = 1'b1;
          state_d         = status_i.last_axis ? S_IDLE : S_DIFF;
        end
      end
      S_STAT: begin
        if (status_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/spqp_dp.sv */
// ----------------------------------------------------------------------------
// spqp_dp
// Datapath of the setpoint queue planner: configuration registers, setpoint
// queue memory with pointers and fill count, speed arithmetic, result register.
// ----------------------------------------------------------------------------
module spqp_dp #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned AXES        = 6
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [spqp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [spqp_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [1:0]                             op_i,
  input  logic signed [spqp_pkg::POS_W-1:0]      pos_a_i,
  input  logic signed [spqp_pkg::POS_W-1:0]      pos_b_i,
  input  logic signed [spqp_pkg::POS_W-1:0]      pos_c_i,
  input  logic signed [spqp_pkg::POS_W-1:0]      pos_d_i,
  input  logic signed [spqp_pkg::POS_W-1:0]      pos_e_i,
  input  logic signed [spqp_pkg::POS_W-1:0]      pos_f_i,
  input  spqp_pkg::cmd_t                         cmd_i,
  output spqp_pkg::status_t                      status_o,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic                                   kind_o,
  output logic [spqp_pkg::AXIS_W-1:0]            axis_o,
  output logic signed [spqp_pkg::POS_W-1:0]      target_o,
  output logic [spqp_pkg::SPEED_W-1:0]           max_speed_o,
  output logic                                   outputs_enabled_o,
  output logic                                   dropped_o,
  output logic [spqp_pkg::FILL_W-1:0]            fill_o,
  output logic                                   last_o
);
  import spqp_pkg::*;

  localparam int unsigned PW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > THR_W) ? CW : THR_W;
  localparam int unsigned AXW  = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned DW   = POS_W + 1;        // absolute difference
  localparam int unsigned PRW  = DW + RATE_W;      // scaled speed
  localparam int unsigned SW   = PRW + 1;          // speed plus offset

  typedef logic [AXES-1:0][POS_W-1:0] row_t;

  // configuration
  logic [THR_W-1:0]  thr_q;
  logic [RATE_W-1:0] rate_q;
  logic [OFF_W-1:0]  off_q;

  // queue control
  logic [PW-1:0] head_q, tail_q, head_inc, tail_inc;
  logic [CW-1:0] count_q;
  logic          primed_q, enabled_q;
  logic [AXES-1:0][POS_W-1:0] prev_q;

  // payload
  row_t          mem [QUEUE_DEPTH];
  row_t          rd_q, now_q, next_q, row_in, item_q;
  op_e           op_q;
  logic [AXW-1:0] axis_q;
  logic [DW-1:0] hsum_q;
  logic [PRW-1:0] prod_q;
  logic [POS_W-1:0] pos_in [8];

  // output register
  logic                 out_valid_q;
  logic                 kind_q, dropped_q, enabled_out_q, last_q;
  logic [AXIS_W-1:0]    axis_out_q;
  logic [POS_W-1:0]     target_q;
  logic [SPEED_W-1:0]   speed_q;
  logic [FILL_W-1:0]    fill_q;

  logic out_free;
  logic full;

  // status-path next values
  logic          enabled_d, primed_d, dropped_d, push;
  logic [CW-1:0] count_d;

  // speed arithmetic
  logic [POS_W-1:0]  prev_s, now_s, next_s;
  logic signed [DW-1:0] d1, d2;
  logic [DW-1:0]     a1, a2;
  logic [DW:0]       dsum;
  logic [SW-1:0]     speed_sum;
  logic [SPEED_W-1:0] speed_sat;

  assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign full     = (count_q == CW'(QUEUE_DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.op        = op_q;
  assign status_o.can_deq   = primed_q && enabled_q && (count_q != '0);
  assign status_o.out_free  = out_free;
  assign status_o.last_axis = (axis_q == AXW'(AXES - 1));

  // input row: axes beyond the six input fields hold zero
  always_comb begin
    pos_in[0] = pos_a_i;
    pos_in[1] = pos_b_i;
    pos_in[2] = pos_c_i;
    pos_in[3] = pos_d_i;
    pos_in[4] = pos_e_i;
    pos_in[5] = pos_f_i;
    pos_in[6] = '0;
    pos_in[7] = '0;
    for (int i = 0; i < AXES; i++) begin
      row_in[i] = (i < IN_AXES) ? pos_in[i] : '0;
    end
  end

  // status handling of a transaction that does not dequeue
  always_comb begin
    enabled_d = enabled_q;
    primed_d  = primed_q;
    dropped_d = 1'b0;
    push      = 1'b0;
    count_d   = count_q;
    unique case (op_q)
      OP_GOOD_FRAME: begin
        enabled_d = 1'b1;
        if (full) begin
          dropped_d = 1'b1;
        end else begin
          push    = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_BAD_FRAME, OP_LINK_LOST: begin
        enabled_d = 1'b0;
      end
      OP_TICK: begin
        if (!primed_q && (CMPW'(count_q) >= CMPW'(thr_q))) begin
          primed_d = 1'b1;
        end
        if (count_q == '0) begin
          primed_d = 1'b0;
        end
      end
    endcase
  end

  // mean step difference of the current axis
  always_comb begin
    prev_s    = prev_q[axis_q];
    now_s     = now_q[axis_q];
    next_s    = next_q[axis_q];
    d1        = $signed({prev_s[POS_W-1], prev_s}) - $signed({now_s[POS_W-1], now_s});
    d2        = $signed({now_s[POS_W-1], now_s}) - $signed({next_s[POS_W-1], next_s});
    a1        = d1[DW-1] ? DW'(-d1) : DW'(d1);
    a2        = d2[DW-1] ? DW'(-d2) : DW'(d2);
    dsum      = {1'b0, a1} + {1'b0, a2};
    speed_sum = {1'b0, prod_q} + SW'(off_q);
    speed_sat = (speed_sum > SW'(SPEED_MAX)) ? SPEED_MAX : speed_sum[SPEED_W-1:0];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      rate_q <= RATE_RESET;
      off_q  <= OFF_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_PRIME_THRESHOLD) thr_q  <= cfg_data_i[THR_W-1:0];
      if (cfg_index_i == REG_RATE_FACTOR)     rate_q <= cfg_data_i[RATE_W-1:0];
      if (cfg_index_i == REG_SPEED_OFFSET)    off_q  <= cfg_data_i[OFF_W-1:0];
    end
  end

  // queue control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      primed_q  <= 1'b0;
      enabled_q <= 1'b0;
      prev_q    <= '0;
      axis_q    <= '0;
    end else begin
      if (cmd_i.emit_status) begin
        enabled_q <= enabled_d;
        primed_q  <= primed_d;
        count_q   <= count_d;
        if (push) tail_q <= tail_inc;
      end
      if (cmd_i.pop) begin
        head_q  <= head_inc;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.take_next) begin
        axis_q <= '0;
      end
      if (cmd_i.emit_move) begin
        prev_q[axis_q] <= now_q[axis_q];
        axis_q         <= axis_q + 1'b1;
        // unprime once the queue runs empty
        if (count_q == '0) primed_q <= 1'b0;
      end
    end
  end

  // setpoint memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status && push) begin
      mem[tail_q] <= item_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_next ? head_inc : head_q];
    end
  end

  // item and arithmetic payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= op_e'(op_i);
      item_q <= row_in;
    end
    if (cmd_i.pop) begin
      now_q <= rd_q;
    end
    if (cmd_i.take_next) begin
      // with an empty queue the look-ahead difference is zero
      next_q <= (count_q != '0) ? rd_q : now_q;
    end
    if (cmd_i.calc_diff) begin
      hsum_q <= dsum[DW:1];
    end
    if (cmd_i.calc_mul) begin
      prod_q <= {{RATE_W{1'b0}}, hsum_q} * {{DW{1'b0}}, rate_q};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_move || cmd_i.emit_status) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status) begin
      kind_q        <= 1'b0;
      axis_out_q    <= '0;
      target_q      <= '0;
      speed_q       <= '0;
      enabled_out_q <= enabled_d;
      dropped_q     <= dropped_d;
      fill_q        <= FILL_W'(count_d);
      last_q        <= 1'b1;
    end else if (cmd_i.emit_move) begin
      kind_q        <= 1'b1;
      axis_out_q    <= AXIS_W'(axis_q);
      target_q      <= now_q[axis_q];
      speed_q       <= speed_sat;
      enabled_out_q <= enabled_q;
      dropped_q     <= 1'b0;
      fill_q        <= FILL_W'(count_q);
      last_q        <= (axis_q == AXW'(AXES - 1));
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign axis_o            = axis_out_q;
  assign target_o          = $signed(target_q);
  assign max_speed_o       = speed_q;
  assign outputs_enabled_o = enabled_out_q;
  assign dropped_o         = dropped_q;
  assign fill_o            = fill_q;
  assign last_o            = last_q;

endmodule
